[design/assert_macros.svh]
// Assertion helpers used by the scanner top.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[design/lmbs_pkg.sv]
package lmbs_pkg;

    localparam int COLUMNS       = 16;
    localparam int ROWS_PER_HALF = 8;
    localparam int PLANES        = 8;
    localparam int COLORS        = 3;
    localparam int BYTE_W        = 8;
    localparam int LINE_W        = COLUMNS * BYTE_W;   // one memory entry: 16 pixel bytes
    localparam int HOLD_UNIT_W   = 12;
    localparam int HOLD_CNT_W    = 19;
    localparam int KIND_W        = 2;
    localparam int SEL_W         = 3;

    localparam logic [KIND_W-1:0] KIND_PIXEL = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SWAP  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ROW   = 2'd2;

    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    typedef logic [COLUMNS-1:0] t_col_word;

endpackage

[design/lmbs_in_if.sv]
interface lmbs_in_if
    import lmbs_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              action;
    logic [BYTE_W-1:0] pixel_byte;

    modport source (output valid, output action, output pixel_byte, input ready);
    modport sink   (input valid, input action, input pixel_byte, output ready);
endinterface

[design/lmbs_out_if.sv]
interface lmbs_out_if
    import lmbs_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    t_col_word         bottom_red;
    t_col_word         bottom_green;
    t_col_word         bottom_blue;
    t_col_word         top_red;
    t_col_word         top_green;
    t_col_word         top_blue;
    logic [SEL_W-1:0]  row_select;
    logic [SEL_W-1:0]  plane;

    modport source (
        output valid, output kind,
        output bottom_red, output bottom_green, output bottom_blue,
        output top_red, output top_green, output top_blue,
        output row_select, output plane,
        input ready
    );
    modport sink (
        input valid, input kind,
        input bottom_red, input bottom_green, input bottom_blue,
        input top_red, input top_green, input top_blue,
        input row_select, input plane,
        output ready
    );
endinterface

[design/led_matrix_bitplane_scanner_top.sv]
// Channel   Dir  Beat contents
// i_in      in   action, pixel_byte
// o_out     out  kind, bottom_red/green/blue, top_red/green/blue, row_select, plane
// i_cfg_*   in   hold_unit write, no handshake
//
// Holding tick: accepted, leaves no result; pixel beat: accept, then hand-off; row-load tick:
// accept, six reads of the single frame-memory port, the read latency, then hand-off of the result.
// After reset a clearing pass zeroes the frame memory; no input beat is taken meanwhile.
// A result waits in the output register; a new input beat is accepted while it waits,
// and that beat's own result stalls until the register frees up.
`include "assert_macros.svh"

module led_matrix_bitplane_scanner_top
    import lmbs_pkg::*;
#(
    parameter int P_ROWS_PER_HALF = ROWS_PER_HALF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [HOLD_UNIT_W-1:0] i_cfg_data,
    lmbs_in_if.sink                i_in,
    lmbs_out_if.source             o_out
);

    localparam int ABS_ROWS = 2 * P_ROWS_PER_HALF;
    localparam int ROW_W    = (ABS_ROWS > 1) ? $clog2(ABS_ROWS) : 1;
    localparam int MEM_AW   = 1 + ROW_W + 2;     // {frame, row, color}
    localparam int MEM_D    = 2 ** MEM_AW;
    localparam int COL_W    = $clog2(COLUMNS);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    // frame memory: one entry holds one color of one row, byte lane = column
    logic [LINE_W-1:0] mem [MEM_D];

    t_state                 r_state;
    logic                   r_clr_busy;
    logic [MEM_AW-1:0]      r_clr_addr;
    logic                   r_front;
    logic [COL_W-1:0]       r_wr_col;
    logic [1:0]             r_wr_color;
    logic [ROW_W-1:0]       r_wr_row;
    logic [SEL_W-1:0]       r_scan_row;
    logic [SEL_W-1:0]       r_scan_plane;
    logic [HOLD_CNT_W-1:0]  r_hold_cnt;
    logic [HOLD_UNIT_W-1:0] r_hold_unit;
    logic [SEL_W-1:0]       r_ld_row;
    logic [SEL_W-1:0]       r_ld_plane;
    logic [KIND_W-1:0]      r_kind;
    logic [2:0]             r_rd_cnt;
    logic [LINE_W-1:0]      r_rd_data;
    t_col_word              r_word [6];

    logic                   r_out_valid;
    logic [KIND_W-1:0]      r_out_kind;
    t_col_word              r_out_word [6];
    logic [SEL_W-1:0]       r_out_row;
    logic [SEL_W-1:0]       r_out_plane;

    logic                   w_acc;
    logic                   w_pix;
    logic                   w_load;
    logic                   w_frame_end;
    logic [MEM_AW-1:0]      w_wr_addr;
    logic                   w_rd_en;
    logic [MEM_AW-1:0]      w_rd_addr;
    logic [1:0]             w_rd_color;
    logic                   w_rd_bottom;
    logic [ROW_W-1:0]       w_rd_row;
    t_col_word              w_col_word;
    logic                   w_out_free;
    logic [HOLD_CNT_W-1:0]  n_hold_cnt;
    logic [HOLD_CNT_W-1:0]  w_unit;

    assign i_in.ready  = (r_state == ST_IDLE) && !r_clr_busy;
    assign w_acc       = i_in.valid && i_in.ready;
    assign w_pix       = w_acc && (i_in.action == ACT_PIXEL);
    assign w_load      = w_acc && (i_in.action == ACT_TICK) && (r_hold_cnt == '0);
    assign w_frame_end = (r_wr_color == 2'd2) && (r_wr_col == COL_W'(COLUMNS - 1))
                         && (r_wr_row == ROW_W'(ABS_ROWS - 1));
    assign w_wr_addr   = {~r_front, r_wr_row, r_wr_color};
    assign w_out_free  = !r_out_valid || o_out.ready;

    assign w_unit     = (r_hold_unit == '0) ? HOLD_CNT_W'(1) : HOLD_CNT_W'(r_hold_unit);
    assign n_hold_cnt = (w_unit << r_scan_plane) - HOLD_CNT_W'(1);

    // read sequence: bottom R,G,B then top R,G,B
    always_comb begin
        w_rd_bottom = 1'b1;
        w_rd_color  = 2'd0;
        case (r_rd_cnt)
            3'd0: begin w_rd_bottom = 1'b1; w_rd_color = 2'd0; end
            3'd1: begin w_rd_bottom = 1'b1; w_rd_color = 2'd1; end
            3'd2: begin w_rd_bottom = 1'b1; w_rd_color = 2'd2; end
            3'd3: begin w_rd_bottom = 1'b0; w_rd_color = 2'd0; end
            3'd4: begin w_rd_bottom = 1'b0; w_rd_color = 2'd1; end
            3'd5: begin w_rd_bottom = 1'b0; w_rd_color = 2'd2; end
            default: begin w_rd_bottom = 1'b0; w_rd_color = 2'd0; end
        endcase
    end

    assign w_rd_row  = w_rd_bottom ? ROW_W'(ROW_W'(P_ROWS_PER_HALF) + ROW_W'(r_ld_row))
                                   : ROW_W'(r_ld_row);
    assign w_rd_addr = {r_front, w_rd_row, w_rd_color};
    assign w_rd_en   = (r_state == ST_READ) && (r_rd_cnt < 3'd6);

    // column c lands at bit (c+8)%16
    always_comb begin
        logic [BYTE_W-1:0] lane;
        w_col_word = '0;
        for (int c = 0; c < COLUMNS; c++) begin
            lane = r_rd_data[c*BYTE_W +: BYTE_W];
            w_col_word[(c + 8) % 16] = lane[r_ld_plane];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            mem[r_clr_addr] <= '0;
        end else if (w_pix) begin
            mem[w_wr_addr][r_wr_col*BYTE_W +: BYTE_W] <= i_in.pixel_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_data <= mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_unit <= HOLD_UNIT_W'(1);
        end else if (i_cfg_we) begin
            r_hold_unit <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_READ && r_rd_cnt != 3'd0) begin
            r_word[r_rd_cnt - 3'd1] <= w_col_word;
        end
        if (w_load) begin
            r_ld_row   <= r_scan_row;
            r_ld_plane <= r_scan_plane;
        end
        if (w_pix) begin
            r_kind <= w_frame_end ? KIND_SWAP : KIND_PIXEL;
        end else if (w_load) begin
            r_kind <= KIND_ROW;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_clr_busy   <= 1'b1;
            r_clr_addr   <= '0;
            r_front      <= 1'b0;
            r_wr_col     <= '0;
            r_wr_color   <= '0;
            r_wr_row     <= '0;
            r_scan_row   <= '0;
            r_scan_plane <= '0;
            r_hold_cnt   <= '0;
            r_rd_cnt     <= '0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + MEM_AW'(1);
                if (r_clr_addr == MEM_AW'(MEM_D - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end

            if (w_pix) begin
                if (w_frame_end) begin
                    r_front    <= ~r_front;
                    r_wr_col   <= '0;
                    r_wr_color <= '0;
                    r_wr_row   <= '0;
                end else if (r_wr_color == 2'd2) begin
                    r_wr_color <= '0;
                    if (r_wr_col == COL_W'(COLUMNS - 1)) begin
                        r_wr_col <= '0;
                        r_wr_row <= r_wr_row + ROW_W'(1);
                    end else begin
                        r_wr_col <= r_wr_col + COL_W'(1);
                    end
                end else begin
                    r_wr_color <= r_wr_color + 2'd1;
                end
            end

            if (w_acc && i_in.action == ACT_TICK) begin
                if (r_hold_cnt != '0) begin
                    r_hold_cnt <= r_hold_cnt - HOLD_CNT_W'(1);
                end else begin
                    r_hold_cnt <= n_hold_cnt;
                    if (r_scan_row == SEL_W'(P_ROWS_PER_HALF - 1)) begin
                        r_scan_row <= '0;
                        r_scan_plane <= (r_scan_plane == SEL_W'(PLANES - 1))
                                        ? '0 : r_scan_plane + SEL_W'(1);
                    end else begin
                        r_scan_row <= r_scan_row + SEL_W'(1);
                    end
                end
            end

            unique case (r_state)
                ST_IDLE: begin
                    r_rd_cnt <= '0;
                    if (w_pix) begin
                        r_state <= ST_DONE;
                    end else if (w_load) begin
                        r_state <= ST_READ;
                    end
                end
                ST_READ: begin
                    r_rd_cnt <= r_rd_cnt + 3'd1;
                    if (r_rd_cnt == 3'd6) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && w_out_free) begin
            r_out_kind <= r_kind;
            for (int k = 0; k < 6; k++) begin
                r_out_word[k] <= (r_kind == KIND_ROW) ? r_word[k] : '0;
            end
            r_out_row   <= (r_kind == KIND_ROW) ? r_ld_row : '0;
            r_out_plane <= (r_kind == KIND_ROW) ? r_ld_plane : '0;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.kind         = r_out_kind;
    assign o_out.bottom_red   = r_out_word[0];
    assign o_out.bottom_green = r_out_word[1];
    assign o_out.bottom_blue  = r_out_word[2];
    assign o_out.top_red      = r_out_word[3];
    assign o_out.top_green    = r_out_word[4];
    assign o_out.top_blue     = r_out_word[5];
    assign o_out.row_select   = r_out_row;
    assign o_out.plane        = r_out_plane;

    `ASSERT_NEXT(a_load_enters_read, i_clk, i_rst_n, w_load, r_state == ST_READ)
    `ASSERT_IMPLIES(a_row_in_range, i_clk, i_rst_n,
        r_out_valid && r_out_kind == KIND_ROW, int'(r_out_row) < P_ROWS_PER_HALF)
    `ASSERT_IMPLIES(a_no_scan_while_clearing, i_clk, i_rst_n,
        r_clr_busy, r_state == ST_IDLE && r_wr_row == '0 && r_hold_cnt == '0)
    `ASSERT_IMPLIES(a_write_row_bound, i_clk, i_rst_n,
        1'b1, r_wr_row < ROW_W'(ABS_ROWS - 1) || r_wr_row == ROW_W'(ABS_ROWS - 1))

endmodule

[tb/led_matrix_bitplane_scanner_top_tb.sv]
module led_matrix_bitplane_scanner_top_tb
    import lmbs_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAME_BYTES    = COLUMNS * 2 * ROWS_PER_HALF * COLORS;
    localparam int LATENCY_PAD    = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int MAX_REPORTS    = 40;
    localparam int C_RED          = 0;
    localparam int C_GREEN        = 1;
    localparam int C_BLUE         = 2;
    localparam logic [HOLD_UNIT_W-1:0] HOLD_UNIT_MAX = '1;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        t_col_word         bottom_red, bottom_green, bottom_blue;
        t_col_word         top_red, top_green, top_blue;
        logic [SEL_W-1:0]  row_select;
        logic [SEL_W-1:0]  plane;
    } t_scan_beat;

    typedef struct {
        logic              act;
        logic [BYTE_W-1:0] pix;
        bit                fixed;
        bit                fixed_has;
        t_scan_beat        fixed_beat;
    } t_directed_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [HOLD_UNIT_W-1:0] i_cfg_data;

    lmbs_in_if  in_bus ();
    lmbs_out_if out_bus ();

    led_matrix_bitplane_scanner_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_bus),
        .o_out      (out_bus)
    );

    // scanner state as the testbench sees it
    logic [BYTE_W-1:0]      frame_mem [2][FRAME_BYTES];
    logic                   front_sel = 1'b0;
    logic [9:0]             wr_idx    = '0;
    logic [SEL_W-1:0]       row_ptr   = '0;
    logic [SEL_W-1:0]       plane_ptr = '0;
    logic [HOLD_CNT_W-1:0]  hold_left = '0;
    logic [HOLD_UNIT_W-1:0] unit_reg  = 1;

    t_scan_beat    expected_scan_out [$];
    t_directed_row directed_rows [$];

    int failures     = 0;
    int n_pixels     = 0;
    int n_swaps      = 0;
    int n_loads      = 0;
    int n_holds      = 0;
    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    int quiet_cycles = 0;
    bit rx_hold_req  = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_col_word plane_word(input int abs_row, input int color, input int pl);
        t_col_word w;
        int        idx;
        int        c;
        w = '0;
        for (c = 0; c < COLUMNS; c++) begin
            idx = ((abs_row * COLUMNS + c) * COLORS + color) % FRAME_BYTES;
            // column c lands at bit (c+8)%16 of the shifted word
            w[(c + 8) % 16] = frame_mem[front_sel][idx][pl];
        end
        return w;
    endfunction

    task automatic predict_scan_beat(input logic act, input logic [BYTE_W-1:0] pix,
                                     output bit has, output t_scan_beat beat);
        logic [31:0] span;
        int          unit;
        int          r;
        beat = '0;
        has  = 1'b1;
        if (act == ACT_PIXEL) begin
            frame_mem[~front_sel][wr_idx] = pix;
            n_pixels++;
            if (int'(wr_idx) + 1 >= FRAME_BYTES) begin
                front_sel = ~front_sel;
                wr_idx    = '0;
                beat.kind = KIND_SWAP;
                n_swaps++;
            end else begin
                wr_idx    = wr_idx + 1'b1;
                beat.kind = KIND_PIXEL;
            end
        end else if (hold_left != 0) begin
            hold_left = hold_left - 1'b1;
            has       = 1'b0;
            n_holds++;
        end else begin
            unit = (unit_reg == 0) ? 1 : int'(unit_reg);
            r    = int'(row_ptr);
            beat.kind         = KIND_ROW;
            beat.bottom_red   = plane_word(ROWS_PER_HALF + r, C_RED,   plane_ptr);
            beat.bottom_green = plane_word(ROWS_PER_HALF + r, C_GREEN, plane_ptr);
            beat.bottom_blue  = plane_word(ROWS_PER_HALF + r, C_BLUE,  plane_ptr);
            beat.top_red      = plane_word(r, C_RED,   plane_ptr);
            beat.top_green    = plane_word(r, C_GREEN, plane_ptr);
            beat.top_blue     = plane_word(r, C_BLUE,  plane_ptr);
            beat.row_select   = row_ptr;
            beat.plane        = plane_ptr;
            // the load tick itself counts toward the hold
            span      = (32'(unit) << plane_ptr) - 1;
            hold_left = span[HOLD_CNT_W-1:0];
            n_loads++;
            if (r == ROWS_PER_HALF - 1) begin
                row_ptr   = '0;
                plane_ptr = (int'(plane_ptr) == PLANES - 1) ? '0 : plane_ptr + 1'b1;
            end else begin
                row_ptr = row_ptr + 1'b1;
            end
        end
    endtask

    // valid stays high after a beat so back-to-back beats never toggle it in one step
    task automatic issue_beat(input logic act, input logic [BYTE_W-1:0] pix,
                              input bit fixed, input bit fixed_has,
                              input t_scan_beat fixed_beat);
        bit         has;
        t_scan_beat beat;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            in_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_bus.valid      <= 1'b1;
        in_bus.action     <= act;
        in_bus.pixel_byte <= pix;
        @(posedge i_clk);
        while (in_bus.ready !== 1'b1) @(posedge i_clk);
        predict_scan_beat(act, pix, has, beat);
        if (fixed) begin
            has  = fixed_has;
            beat = fixed_beat;
        end
        if (has) expected_scan_out.push_back(beat);
    endtask

    task automatic wait_for_results();
        in_bus.valid <= 1'b0;
        while (expected_scan_out.size() != 0) @(posedge i_clk);
        // a holding tick leaves no result behind, so give the block time to settle
        repeat (LATENCY_PAD) @(posedge i_clk);
    endtask

    task automatic write_hold_unit(input logic [HOLD_UNIT_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        unit_reg = value;
    endtask

    task automatic add_directed(input logic act, input logic [BYTE_W-1:0] pix,
                                input bit fixed, input bit fixed_has,
                                input logic [KIND_W-1:0] kind,
                                input int row, input int pl);
        t_directed_row d;
        d.act                   = act;
        d.pix                   = pix;
        d.fixed                 = fixed;
        d.fixed_has             = fixed_has;
        d.fixed_beat            = '0;
        d.fixed_beat.kind       = kind;
        d.fixed_beat.row_select = SEL_W'(row);
        d.fixed_beat.plane      = SEL_W'(pl);
        directed_rows.push_back(d);
    endtask

    task automatic run_phase(input logic [HOLD_UNIT_W-1:0] unit, input int n_items,
                             input int pix_pct, input bit fill_frame, input bit settle,
                             input bit long_hold, input bit mid_pause);
        logic act;
        int   i;
        write_hold_unit(unit);
        for (i = 0; i < n_items; i++) begin
            if (long_hold && i == n_items / 4) rx_hold_req = 1'b1;
            if (mid_pause && i == n_items / 2) wait_for_results();
            act = ($urandom_range(0, 99) < pix_pct) ? ACT_PIXEL : ACT_TICK;
            issue_beat(act, BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
        end
        // complete the frame so the next ticks show freshly written data
        if (fill_frame) begin
            do issue_beat(ACT_PIXEL, BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
            while (wr_idx != 0);
        end
        // run out the hold so the next unit takes effect on the very next tick
        if (settle) begin
            while (hold_left != 0)
                issue_beat(ACT_TICK, BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
        end
        wait_for_results();
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            failures++;
            if (failures <= MAX_REPORTS)
                $display("%0t ns: %s mismatch, expected 0x%h, got 0x%h",
                         $time, name, want, got);
        end
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        out_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                out_bus.ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
            end
            out_bus.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_scan_beat want;
        t_scan_beat got;
        if (i_rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
            got = {out_bus.kind, out_bus.bottom_red, out_bus.bottom_green,
                   out_bus.bottom_blue, out_bus.top_red, out_bus.top_green,
                   out_bus.top_blue, out_bus.row_select, out_bus.plane};
            if (expected_scan_out.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("%0t ns: unexpected beat, expected none, got kind %0d",
                             $time, got.kind);
            end else begin
                want = expected_scan_out.pop_front();
                check_field("kind",         16'(want.kind),       16'(got.kind));
                check_field("bottom_red",   want.bottom_red,      got.bottom_red);
                check_field("bottom_green", want.bottom_green,    got.bottom_green);
                check_field("bottom_blue",  want.bottom_blue,     got.bottom_blue);
                check_field("top_red",      want.top_red,         got.top_red);
                check_field("top_green",    want.top_green,       got.top_green);
                check_field("top_blue",     want.top_blue,        got.top_blue);
                check_field("row_select",   16'(want.row_select), 16'(got.row_select));
                check_field("plane",        16'(want.plane),      16'(got.plane));
            end
        end
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_bus.valid === 1'b1 && in_bus.ready === 1'b1) ||
                (out_bus.valid === 1'b1 && out_bus.ready === 1'b1))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t ns: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("[led_matrix_bitplane_scanner_top] ERROR");
        $finish;
    end

    initial begin
        logic [HOLD_UNIT_W-1:0] mid_unit;
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_data        <= '0;
        in_bus.valid      <= 1'b0;
        in_bus.action     <= ACT_PIXEL;
        in_bus.pixel_byte <= '0;
        foreach (frame_mem[f, b]) frame_mem[f][b] = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        tx_idle_pct = 8;
        rx_idle_pct = 79;

        // front frame is all zero, so every early row load is blank
        add_directed(ACT_TICK,  8'h00, 1, 1, KIND_ROW,   0, 0);
        add_directed(ACT_TICK,  8'hFF, 1, 1, KIND_ROW,   1, 0);
        add_directed(ACT_PIXEL, 8'hFF, 1, 1, KIND_PIXEL, 0, 0);
        add_directed(ACT_PIXEL, 8'h00, 1, 1, KIND_PIXEL, 0, 0);
        add_directed(ACT_PIXEL, 8'h80, 1, 1, KIND_PIXEL, 0, 0);
        add_directed(ACT_PIXEL, 8'h01, 1, 1, KIND_PIXEL, 0, 0);
        add_directed(ACT_PIXEL, 8'h55, 0, 0, KIND_PIXEL, 0, 0);
        add_directed(ACT_PIXEL, 8'hAA, 0, 0, KIND_PIXEL, 0, 0);
        for (int r = 2; r < ROWS_PER_HALF; r++)
            add_directed(ACT_TICK, 8'h00, 1, 1, KIND_ROW, r, 0);
        // plane 1: each row is held for two ticks
        add_directed(ACT_TICK,  8'h00, 1, 1, KIND_ROW,   0, 1);
        add_directed(ACT_TICK,  8'h00, 1, 0, KIND_ROW,   0, 0);
        add_directed(ACT_TICK,  8'h00, 1, 1, KIND_ROW,   1, 1);
        add_directed(ACT_TICK,  8'h3C, 1, 0, KIND_ROW,   0, 0);
        add_directed(ACT_PIXEL, 8'h7F, 0, 0, KIND_PIXEL, 0, 0);
        add_directed(ACT_PIXEL, 8'hFE, 0, 0, KIND_PIXEL, 0, 0);
        add_directed(ACT_TICK,  8'h00, 1, 1, KIND_ROW,   2, 1);
        foreach (directed_rows[i])
            issue_beat(directed_rows[i].act, directed_rows[i].pix, directed_rows[i].fixed,
                       directed_rows[i].fixed_has, directed_rows[i].fixed_beat);
        wait_for_results();

        // zero unit behaves as one
        run_phase(0, 100, 80, 1'b0, 1'b0, 1'b0, 1'b0);

        tx_idle_pct = 79;
        rx_idle_pct = 8;
        run_phase(2, 100, 50, 1'b1, 1'b0, 1'b1, 1'b1);
        // tick-heavy stretch walks the scan on into the longer planes
        run_phase(1, 120, 3, 1'b0, 1'b0, 1'b0, 1'b0);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        mid_unit = HOLD_UNIT_W'($urandom_range(3, 5));
        run_phase(mid_unit, 60, 40, 1'b0, 1'b1, 1'b0, 1'b0);
        run_phase(HOLD_UNIT_MAX, 60, 30, 1'b0, 1'b0, 1'b0, 1'b0);

        $display("Covered %0d pixel beats, %0d frame swaps, %0d row loads, %0d held ticks.",
                 n_pixels, n_swaps, n_loads, n_holds);
        $display("Hold units 1, 0, 2, 1, %0d and %0d under three stall mixes.",
                 mid_unit, HOLD_UNIT_MAX);
        if (failures == 0 && expected_scan_out.size() == 0) begin
            $display("[led_matrix_bitplane_scanner_top] OK");
        end else begin
            $display("%0d mismatches, %0d beats still outstanding",
                     failures, expected_scan_out.size());
            $display("[led_matrix_bitplane_scanner_top] ERROR");
        end
        $finish;
    end

endmodule
